### design/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/gn3_pkg.sv
`timescale 1ns / 1ps
// Package: widths and codes for the 3D gradient noise core
package gn3_pkg;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int INTEGER_BITS_DEF  = 16;
  localparam int COORD_W           = 32;
  localparam int OUT_W             = 18;
  localparam int OUT_FRAC          = 16;
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  typedef logic [7:0] perm_t;
endpackage

### design/gn3_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the noise core
interface gn3_in_if import gn3_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [7:0]                entry_index;
  logic [7:0]                entry_value;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  modport source (output valid, kind, entry_index, entry_value, coord_x, coord_y, coord_z,
                  input ready);
  modport sink (input valid, kind, entry_index, entry_value, coord_x, coord_y, coord_z,
                output ready);
endinterface

interface gn3_out_if import gn3_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface

### design/gradient_noise_3d_core.sv
`timescale 1ns / 1ps
// Sequence: a load request is written in the cycle it is taken; an evaluate request runs
// the fade of each axis in turn on the shared multiplier, fourteen dependent permutation
// reads and seven lerps, and then writes the result register.
// Throughput: loads one per cycle while no evaluation is in progress; an evaluation must
// finish before the next request is taken. A waiting result holds off evaluate requests
// only. Reset (rst, synchronous) clears control; the table is undefined.
`include "assert_macros.svh"
module gradient_noise_3d_core import gn3_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int INTEGER_BITS  = INTEGER_BITS_DEF
) (
  input logic    clk,
  input logic    rst,
  gn3_in_if.sink   in_req,
  gn3_out_if.source out_res
);
  localparam int FW = FRACTION_BITS;
  localparam int VW = FW + 6;            // working width for signed values (|v| < 32)
  localparam int PW = 2 * VW;
  localparam int RW = VW + OUT_FRAC;
  localparam int CB = (INTEGER_BITS < 8) ? INTEGER_BITS : 8;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FADE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_HWAIT = 4'd3;
  localparam logic [3:0] S_LERP  = 4'd4;
  localparam logic [3:0] S_LWAIT = 4'd5;
  localparam logic [3:0] S_DONE  = 4'd6;

  perm_t perm_mem [256];
  perm_t rd_data;
  perm_t rd_addr;
  logic  wr_en;

  logic [3:0] state;
  logic [3:0] step;
  logic [2:0] sub;
  logic [7:0] lattice [3];
  logic signed [VW-1:0] frac [3];
  logic signed [VW-1:0] fad [3];
  logic signed [VW-1:0] tt;
  logic signed [VW-1:0] t3;
  logic signed [VW-1:0] pp;
  logic [7:0] hreg [6];   // a, b, aa, ab, ba, bb
  logic signed [VW-1:0] val [8];
  logic signed [VW-1:0] mul_a;
  logic signed [VW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [VW-1:0] prod_q;
  logic signed [VW-1:0] unit;
  logic signed [VW-1:0] dotv;
  logic [1:0] fi;
  logic signed [RW-1:0] res_full;
  logic signed [OUT_W-1:0] res_sat;
  logic busy;

  assign unit = VW'(1) <<< FW;
  assign busy = (state != S_IDLE);
  assign in_req.ready = !busy && !(out_res.valid && !out_res.ready && in_req.kind == KIND_EVAL);
  assign wr_en = in_req.valid && in_req.ready && in_req.kind == KIND_LOAD;

  always_ff @(posedge clk) begin
    if (wr_en) perm_mem[in_req.entry_index] <= in_req.entry_value;
    rd_data <= perm_mem[rd_addr];
  end

  // shared multiplier, registered; floor by arithmetic shift
  always_ff @(posedge clk) begin
    prod   <= mul_a * mul_b;
  end
  assign prod_q = VW'(prod >>> FW);

  // hash read schedule: step 0..13
  always_comb begin
    case (step)
      4'd0:  rd_addr = lattice[0];
      4'd1:  rd_addr = lattice[0] + 8'd1;
      4'd2:  rd_addr = hreg[0];
      4'd3:  rd_addr = hreg[0] + 8'd1;
      4'd4:  rd_addr = hreg[1];
      4'd5:  rd_addr = hreg[1] + 8'd1;
      4'd6:  rd_addr = hreg[2];
      4'd7:  rd_addr = hreg[4];
      4'd8:  rd_addr = hreg[3];
      4'd9:  rd_addr = hreg[5];
      4'd10: rd_addr = hreg[2] + 8'd1;
      4'd11: rd_addr = hreg[4] + 8'd1;
      4'd12: rd_addr = hreg[3] + 8'd1;
      default: rd_addr = hreg[5] + 8'd1;
    endcase
  end

  // gradient dot for the corner of the current step (6..13)
  always_comb begin
    logic [3:0] h;
    logic [2:0] c;
    logic signed [VW-1:0] px, py, pz, p, q;
    h  = rd_data[3:0];
    c  = 3'(step - 4'd6);
    px = c[0] ? frac[0] - unit : frac[0];
    py = c[1] ? frac[1] - unit : frac[1];
    pz = c[2] ? frac[2] - unit : frac[2];
    p  = (h < 4'd8) ? px : py;
    q  = (h < 4'd4) ? py : ((h == 4'd12 || h == 4'd14) ? px : pz);
    dotv = (h[0] ? -p : p) + (h[1] ? -q : q);
  end

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_FADE) begin
      case (sub)
        3'd0: begin mul_a = tt; mul_b = tt; end
        3'd1: begin mul_a = prod_q; mul_b = tt; end
        3'd2: begin mul_a = tt; mul_b = VW'(6 * tt - 15 * unit); end
        3'd4: begin mul_a = t3; mul_b = pp; end
        default: ;
      endcase
    end else begin
      case (step)
        4'd0, 4'd1, 4'd2, 4'd3: begin
          mul_a = fad[0]; mul_b = val[{step[1:0], 1'b1}] - val[{step[1:0], 1'b0}];
        end
        4'd4, 4'd5: begin
          mul_a = fad[1]; mul_b = val[{1'b0, step[0], 1'b1}] - val[{1'b0, step[0], 1'b0}];
        end
        default: begin mul_a = fad[2]; mul_b = val[3'd1] - val[3'd0]; end
      endcase
    end
  end

  always_comb begin
    if (FW >= OUT_FRAC) res_full = RW'(val[0]) >>> (FW - OUT_FRAC);
    else res_full = RW'(val[0]) <<< (OUT_FRAC - FW);
    if (res_full > RW'(131071)) res_sat = OUT_W'(131071);
    else if (res_full < RW'(-131072)) res_sat = OUT_W'(-131072);
    else res_sat = OUT_W'(res_full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_res.valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_res.valid || out_res.ready)) out_res.valid <= 1'b1;
      else if (out_res.valid && out_res.ready) out_res.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_req.valid && in_req.ready && in_req.kind == KIND_EVAL) begin
            lattice[0] <= 8'(in_req.coord_x[FW +: CB]);
            lattice[1] <= 8'(in_req.coord_y[FW +: CB]);
            lattice[2] <= 8'(in_req.coord_z[FW +: CB]);
            frac[0] <= VW'({1'b0, in_req.coord_x[FW-1:0]});
            frac[1] <= VW'({1'b0, in_req.coord_y[FW-1:0]});
            frac[2] <= VW'({1'b0, in_req.coord_z[FW-1:0]});
            tt    <= VW'({1'b0, in_req.coord_x[FW-1:0]});
            fi    <= 2'd0;
            sub   <= 3'd0;
            state <= S_FADE;
          end
        end
        S_FADE: begin
          // products are registered and land in the cycle after their operands; each axis steps sub 0..5
          case (sub)
            3'd2: begin
              t3  <= prod_q;                // t2*t
              sub <= sub + 3'd1;
            end
            3'd3: begin
              pp  <= VW'(prod_q + 10 * unit);
              sub <= sub + 3'd1;
            end
            3'd5: begin
              sub     <= 3'd0;
              fad[fi] <= prod_q;
              if (fi == 2'd2) begin
                step  <= 4'd0;
                state <= S_HASH;
              end else begin
                fi <= fi + 2'd1;
                tt <= frac[fi + 2'd1];
              end
            end
            default: sub <= sub + 3'd1;
          endcase
        end
        S_HASH: state <= S_HWAIT;
        S_HWAIT: begin
          case (step)
            4'd0: hreg[0] <= rd_data + lattice[1];
            4'd1: hreg[1] <= rd_data + lattice[1];
            4'd2: hreg[2] <= rd_data + lattice[2];
            4'd3: hreg[3] <= rd_data + lattice[2];
            4'd4: hreg[4] <= rd_data + lattice[2];
            4'd5: hreg[5] <= rd_data + lattice[2];
            default: val[3'(step - 4'd6)] <= dotv;
          endcase
          if (step == 4'd13) begin
            step  <= 4'd0;
            state <= S_LERP;
          end else begin
            step  <= step + 4'd1;
            state <= S_HASH;
          end
        end
        S_LERP: state <= S_LWAIT;
        S_LWAIT: begin
          case (step)
            4'd0, 4'd1, 4'd2, 4'd3: val[{1'b0, step[1:0]}] <= val[{step[1:0], 1'b0}] + prod_q;
            4'd4, 4'd5: val[{2'b00, step[0]}] <= val[{1'b0, step[0], 1'b0}] + prod_q;
            default: val[0] <= val[0] + prod_q;
          endcase
          if (step == 4'd6) state <= S_DONE;
          else begin
            step  <= step + 4'd1;
            state <= S_LERP;
          end
        end
        S_DONE: begin
          if (!out_res.valid || out_res.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_res.valid || out_res.ready)) out_res.noise_value <= res_sat;
  end

  `CHK_IMPLY(a_no_accept_busy, clk, rst, busy, !in_req.ready, "request accepted while busy")
  `CHK_NEXT(a_done_valid, clk, rst, state == S_DONE && (!out_res.valid || out_res.ready),
    out_res.valid, "result not presented")
  `CHK_NEXT(a_eval_starts, clk, rst, in_req.valid && in_req.ready && in_req.kind == KIND_EVAL,
    state == S_FADE, "evaluation did not start")
endmodule
